FILE: sv/fixed_slot_allocator_top_assert.svh
// assertion macros for the fixed slot allocator
`ifndef FIXED_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define FIXED_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// condition in this cycle implies consequence in the next one
`define FSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// condition implies consequence in the same cycle
`define FSA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/fsa_pkg.sv
package fsa_pkg;

  localparam int ADDR_W = 48;
  localparam int SIZE_W = 32;
  localparam int FUNC_W = 2;
  localparam int OUTC_W = 2;

  localparam int DEF_SLOT_COUNT = 128;
  localparam int DEF_SLOT_BYTES = 1024;
  localparam int MIN_REQUEST    = 8;

  // apb byte address of the pool base register
  localparam logic [2:0] REG_POOL_BASE = 3'd0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_REALLOC = 2'd2
  } func_e;

  typedef enum logic [OUTC_W-1:0] {
    OUT_POOL       = 2'd0,
    OUT_SYSTEM     = 2'd1,
    OUT_MISALIGNED = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_LOOKUP = 2'd1,
    ST_REPLY  = 2'd2
  } state_e;

  typedef struct packed {
    logic capture;
    logic decide;
  } fsa_cmd_t;

endpackage

FILE: sv/fsa_ctrl.sv
module fsa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  output logic            done_o,
  output fsa_pkg::fsa_cmd_t cmd_o
);
  import fsa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    busy_o      = 1'b0;
    done_o      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        busy_o       = 1'b1;
        cmd_o.decide = 1'b1;
        state_d      = ST_REPLY;
      end
      ST_REPLY: begin
        // word is on the outputs; the next request may enter right away
        done_o = 1'b1;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOKUP;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/fsa_datapath.sv
module fsa_datapath #(
  parameter int SLOT_COUNT = fsa_pkg::DEF_SLOT_COUNT,
  parameter int SLOT_BYTES = fsa_pkg::DEF_SLOT_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fsa_pkg::fsa_cmd_t           cmd_i,
  input  logic [fsa_pkg::ADDR_W-1:0]  pool_base_i,
  input  logic [fsa_pkg::FUNC_W-1:0]  func_i,
  input  logic [fsa_pkg::SIZE_W-1:0]  request_size_i,
  input  logic [fsa_pkg::ADDR_W-1:0]  block_address_i,
  output logic [fsa_pkg::ADDR_W-1:0]  result_address_o,
  output logic [fsa_pkg::OUTC_W-1:0]  outcome_o,
  output logic                        copy_needed_o
);
  import fsa_pkg::*;

  // slot size is a power of two, so slot math is shifts and masks
  localparam int SW = $clog2(SLOT_COUNT);
  localparam int SH = $clog2(SLOT_BYTES);
  localparam int HW = ADDR_W - SH;
  localparam logic [HW-1:0]     COUNT_LIM  = HW'(SLOT_COUNT);
  localparam logic [SIZE_W-1:0] BYTES_LIM  = SIZE_W'(SLOT_BYTES);
  localparam logic [SIZE_W-1:0] MIN_SIZE   = SIZE_W'(MIN_REQUEST);

  logic [SLOT_COUNT-1:0] used_q, used_d;
  logic [FUNC_W-1:0]     func_q;
  logic [SIZE_W-1:0]     size_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [ADDR_W-1:0]     res_addr_q;
  logic [OUTC_W-1:0]     outcome_q;
  logic                  copy_q;

  logic [ADDR_W-1:0] offset;
  logic              in_pool;
  logic              misaligned;
  logic [SW-1:0]     loc_slot;
  logic              free_found;
  logic [SW-1:0]     free_slot;
  logic [SW-1:0]     sel_slot;
  logic [ADDR_W-1:0] slot_addr;
  logic              wr_en;
  logic              wr_val;
  logic              addr_valid;
  logic [OUTC_W-1:0] outcome_d;
  logic              copy_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      size_q <= request_size_i;
      addr_q <= block_address_i;
    end
    if (cmd_i.decide) begin
      res_addr_q <= addr_valid ? slot_addr : '0;
      outcome_q  <= outcome_d;
      copy_q     <= copy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  // map the address back to a slot
  assign offset     = addr_q - pool_base_i;
  assign in_pool    = offset[ADDR_W-1:SH] < COUNT_LIM;
  assign misaligned = |offset[SH-1:0];
  assign loc_slot   = offset[SH+SW-1:SH];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
    end
  end

  assign sel_slot  = (func_q == FUNC_ALLOC) ? free_slot : loc_slot;
  assign slot_addr = pool_base_i + (ADDR_W'(sel_slot) << SH);

  always_comb begin
    wr_en      = 1'b0;
    wr_val     = 1'b0;
    addr_valid = 1'b0;
    outcome_d  = OUT_POOL;
    copy_d     = 1'b0;
    case (func_q)
      FUNC_ALLOC: begin
        outcome_d = OUT_SYSTEM;
        if (size_q >= MIN_SIZE && size_q <= BYTES_LIM && free_found) begin
          wr_en      = 1'b1;
          wr_val     = 1'b1;
          addr_valid = 1'b1;
          outcome_d  = OUT_POOL;
        end
      end
      FUNC_FREE, FUNC_REALLOC: begin
        if (!in_pool) begin
          outcome_d = OUT_SYSTEM;
        end else if (misaligned) begin
          outcome_d = OUT_MISALIGNED;
        end else if (func_q == FUNC_FREE) begin
          wr_en = 1'b1;
        end else if (size_q > BYTES_LIM) begin
          // grows past the slot: release it and hand off to the system heap
          wr_en     = 1'b1;
          outcome_d = OUT_SYSTEM;
          copy_d    = 1'b1;
        end else begin
          addr_valid = 1'b1;
        end
      end
      default: begin
        outcome_d = OUT_POOL;
      end
    endcase
  end

  always_comb begin
    used_d = used_q;
    if (cmd_i.decide && wr_en) begin
      used_d[sel_slot] = wr_val;
    end
  end

  assign result_address_o = res_addr_q;
  assign outcome_o        = outcome_q;
  assign copy_needed_o    = copy_q;

endmodule

FILE: sv/fixed_slot_allocator_top.sv
// fixed slot pool allocator
// requests enter on start/busy: a word (func, request size, block address)
// is taken at a clock edge where start is high and busy is low. each request
// gives exactly one result word, shown for one cycle with done_o high; the
// receiver cannot hold results off, so the block never stalls on output.
// a request taken at an edge goes to the lookup state, where its result is
// registered, and the result is marked in the reply state. busy is high only
// in the lookup cycle, in which the lowest free slot is found by a single
// priority pass over the used bitmap and the bitmap is updated at its end; a
// new request can be taken in the same cycle the previous result is shown.
// pool_base is written through the apb port at byte address 0 (64-bit data,
// low 48 bits used); write it only while the block is idle.
// slot size must be a power of two; slot address = pool_base + slot * size.
// reset clears the used bitmap (all slots free) and pool_base to zero; no
// clearing pass is needed.
module fixed_slot_allocator_top #(
  parameter int SLOT_COUNT = fsa_pkg::DEF_SLOT_COUNT,
  parameter int SLOT_BYTES = fsa_pkg::DEF_SLOT_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [fsa_pkg::FUNC_W-1:0]  func_i,
  input  logic [fsa_pkg::SIZE_W-1:0]  request_size_i,
  input  logic [fsa_pkg::ADDR_W-1:0]  block_address_i,
  output logic                        done_o,
  output logic [fsa_pkg::ADDR_W-1:0]  result_address_o,
  output logic [fsa_pkg::OUTC_W-1:0]  outcome_o,
  output logic                        copy_needed_o
);
  import fsa_pkg::*;

  logic [ADDR_W-1:0] pool_base_q;
  fsa_cmd_t          cmd;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_POOL_BASE);
  assign prdata = (paddr == REG_POOL_BASE) ? {{(64-ADDR_W){1'b0}}, pool_base_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
    end else if (cfg_wr) begin
      pool_base_q <= pwdata[ADDR_W-1:0];
    end
  end

  fsa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  fsa_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .pool_base_i      (pool_base_q),
    .func_i           (func_i),
    .request_size_i   (request_size_i),
    .block_address_i  (block_address_i),
    .result_address_o (result_address_o),
    .outcome_o        (outcome_o),
    .copy_needed_o    (copy_needed_o)
  );

`include "fixed_slot_allocator_top_assert.svh"

  `FSA_ASSERT_NEXT(a_accept_lookup, start && !busy, busy, "accepted word did not enter lookup")
  `FSA_ASSERT_NEXT(a_lookup_reply, busy, done_o && !busy, "lookup not followed by result")
  `FSA_ASSERT_SAME(a_copy_system, done_o && copy_needed_o,
                   outcome_o == OUT_SYSTEM && result_address_o == '0, "copy without handoff")
  `FSA_ASSERT_SAME(a_misalign_zero, done_o && outcome_o == OUT_MISALIGNED,
                   result_address_o == '0 && !copy_needed_o, "misaligned result not clean")

endmodule

FILE: bench/fixed_slot_allocator_top_tb.sv
module fixed_slot_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fsa_pkg::*;

  localparam int SLOT_COUNT = DEF_SLOT_COUNT;
  localparam int SLOT_BYTES = DEF_SLOT_BYTES;
  localparam longint POOL_BYTES = longint'(SLOT_COUNT) * SLOT_BYTES;
  localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 305;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    outcome_e          outcome;
    logic              copy;
  } reply_t;

  typedef struct packed {
    logic [FUNC_W-1:0] fn;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    logic              typed;
    reply_t            want;
  } plan_row_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic              rand_base;
    logic [6:0]        alloc_pct;
    logic              idle_on;
  } phase_t;

  // pool_base is zero for the whole directed walk
  localparam int PLAN_LEN = 23;
  localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
    '{FUNC_ALLOC,   32'd8,          48'h0,            1'b1, '{48'h0,     OUT_POOL,       1'b0}},
    '{FUNC_ALLOC,   32'd1024,       48'hffff_ffff_ffff, 1'b1, '{48'h400, OUT_POOL,       1'b0}},
    '{FUNC_ALLOC,   32'd7,          48'h0,            1'b1, '{48'h0,     OUT_SYSTEM,     1'b0}},
    '{FUNC_ALLOC,   32'd1025,       48'h0,            1'b1, '{48'h0,     OUT_SYSTEM,     1'b0}},
    '{FUNC_ALLOC,   32'd0,          48'h0,            1'b1, '{48'h0,     OUT_SYSTEM,     1'b0}},
    '{FUNC_ALLOC,   32'hffff_ffff,  48'h0,            1'b1, '{48'h0,     OUT_SYSTEM,     1'b0}},
    '{FUNC_FREE,    32'hffff_ffff,  48'h400,          1'b1, '{48'h0,     OUT_POOL,       1'b0}},
    '{FUNC_FREE,    32'd0,          48'h400,          1'b1, '{48'h0,     OUT_POOL,       1'b0}},
    '{FUNC_FREE,    32'd0,          48'h3ff,          1'b1, '{48'h0,     OUT_MISALIGNED, 1'b0}},
    '{FUNC_FREE,    32'd0,          48'h20000,        1'b1, '{48'h0,     OUT_SYSTEM,     1'b0}},
    '{FUNC_FREE,    32'd0,          48'hffff_ffff_ffff, 1'b1, '{48'h0,   OUT_SYSTEM,     1'b0}},
    '{FUNC_REALLOC, 32'd1024,       48'h0,            1'b1, '{48'h0,     OUT_POOL,       1'b0}},
    '{FUNC_ALLOC,   32'd100,        48'h0,            1'b1, '{48'h400,   OUT_POOL,       1'b0}},
    '{FUNC_REALLOC, 32'd0,          48'h400,          1'b1, '{48'h400,   OUT_POOL,       1'b0}},
    '{FUNC_REALLOC, 32'd1025,       48'h400,          1'b1, '{48'h0,     OUT_SYSTEM,     1'b1}},
    '{FUNC_REALLOC, 32'd4,          48'h1fc00,        1'b1, '{48'h1fc00, OUT_POOL,       1'b0}},
    '{FUNC_REALLOC, 32'hffff_ffff,  48'h1fc01,        1'b1, '{48'h0,     OUT_MISALIGNED, 1'b0}},
    '{FUNC_REALLOC, 32'd1,          48'h20000,        1'b1, '{48'h0,     OUT_SYSTEM,     1'b0}},
    '{FUNC_UNKNOWN, 32'hffff_ffff,  48'hffff_ffff_ffff, 1'b1, '{48'h0,   OUT_POOL,       1'b0}},
    '{FUNC_REALLOC, 32'hffff_ffff,  48'h0,            1'b1, '{48'h0,     OUT_SYSTEM,     1'b1}},
    '{FUNC_ALLOC,   32'd1024,       48'h0,            1'b1, '{48'h0,     OUT_POOL,       1'b0}},
    '{FUNC_ALLOC,   32'd9,          48'h0,            1'b0, '{48'h0,     OUT_POOL,       1'b0}},
    '{FUNC_FREE,    32'd0,          48'h1fc00,        1'b0, '{48'h0,     OUT_POOL,       1'b0}}
  };

  localparam int PHASE_LEN = 6;
  localparam phase_t PHASES [PHASE_LEN] = '{
    '{48'h0000_0001_0000, 1'b0, 7'd45, 1'b1},
    '{48'hffff_ffff_ffff, 1'b0, 7'd80, 1'b1},
    '{48'hffff_ffff_8000, 1'b0, 7'd40, 1'b0},
    '{48'h0,              1'b1, 7'd50, 1'b1},
    '{48'h0,              1'b0, 7'd85, 1'b1},
    '{48'h0,              1'b1, 7'd35, 1'b1}
  };

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [63:0]       pwdata = '0;
  logic [63:0]       prdata;
  logic              pready;
  logic              start = 1'b0;
  logic              busy;
  logic [FUNC_W-1:0] func_i = '0;
  logic [SIZE_W-1:0] request_size_i = '0;
  logic [ADDR_W-1:0] block_address_i = '0;
  logic              done_o;
  logic [ADDR_W-1:0] result_address_o;
  logic [OUTC_W-1:0] outcome_o;
  logic              copy_needed_o;

  logic [SLOT_COUNT-1:0] slot_taken = '0;
  logic [ADDR_W-1:0]     base_reg = '0;
  reply_t                awaited_replies [$];
  int                    bad_replies = 0;
  int                    stall_cycles = 0;

  fixed_slot_allocator_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .request_size_i   (request_size_i),
    .block_address_i  (block_address_i),
    .done_o           (done_o),
    .result_address_o (result_address_o),
    .outcome_o        (outcome_o),
    .copy_needed_o    (copy_needed_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic [ADDR_W-1:0] slot_address(int slot);
    return base_reg + ADDR_W'(slot * SLOT_BYTES);
  endfunction

  // expected reply for one request; updates the bitmap copy
  function automatic reply_t allocator_reply(logic [FUNC_W-1:0] fn, logic [SIZE_W-1:0] size,
                                             logic [ADDR_W-1:0] addr);
    reply_t r;
    logic [ADDR_W-1:0] off;
    logic found;
    int slot;
    r = '{addr: '0, outcome: OUT_POOL, copy: 1'b0};
    found = 1'b0;
    off = addr - base_reg;
    slot = int'(off / SLOT_BYTES);
    case (fn)
      FUNC_ALLOC: begin
        r.outcome = OUT_SYSTEM;
        if (size >= MIN_REQUEST && size <= SLOT_BYTES) begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!found && !slot_taken[i]) begin
              found = 1'b1;
              slot_taken[i] = 1'b1;
              r.addr = slot_address(i);
              r.outcome = OUT_POOL;
            end
          end
        end
      end
      FUNC_FREE, FUNC_REALLOC: begin
        if (off >= POOL_BYTES) begin
          r.outcome = OUT_SYSTEM;
        end else if (off % SLOT_BYTES != 0) begin
          r.outcome = OUT_MISALIGNED;
        end else if (fn == FUNC_FREE) begin
          slot_taken[slot] = 1'b0;
        end else if (size > SLOT_BYTES) begin
          // grows past the slot: slot released, caller copies to a system block
          slot_taken[slot] = 1'b0;
          r.outcome = OUT_SYSTEM;
          r.copy = 1'b1;
        end else begin
          r.addr = slot_address(slot);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap(logic idle_on);
    int roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 2);
    if (roll < 97) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  // mostly slot-aligned addresses, half of them on slots in use
  function automatic logic [ADDR_W-1:0] pick_address();
    int k;
    int kind;
    logic [63:0] wide;
    k = $urandom_range(0, SLOT_COUNT - 1);
    kind = $urandom_range(0, 9);
    wide = {$urandom, $urandom};
    if (slot_taken != '0 && $urandom_range(0, 1) == 1) begin
      while (!slot_taken[k]) k = (k + 1) % SLOT_COUNT;
    end
    if (kind <= 5) return slot_address(k);
    if (kind == 6) return slot_address(k) + ADDR_W'($urandom_range(1, SLOT_BYTES - 1));
    if (kind == 7) return base_reg + ADDR_W'(POOL_BYTES) + ADDR_W'($urandom_range(0, 4095));
    if (kind == 8) return base_reg - ADDR_W'($urandom_range(1, 4096));
    return wide[ADDR_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(logic [FUNC_W-1:0] fn);
    int roll;
    roll = $urandom_range(0, 9);
    if (fn == FUNC_ALLOC) begin
      if (roll < 7) return $urandom_range(MIN_REQUEST, SLOT_BYTES);
      if (roll == 7) return $urandom_range(0, MIN_REQUEST - 1);
      if (roll == 8) return $urandom_range(SLOT_BYTES + 1, 2 * SLOT_BYTES);
      return $urandom;
    end
    if (roll < 6) return $urandom_range(0, SLOT_BYTES);
    if (roll < 8) return $urandom_range(SLOT_BYTES + 1, 4 * SLOT_BYTES);
    return $urandom;
  endfunction

  // drives one request word and waits until the block takes it
  task automatic issue(logic [FUNC_W-1:0] fn, logic [SIZE_W-1:0] size,
                       logic [ADDR_W-1:0] addr, logic typed, reply_t want);
    reply_t r;
    start <= 1'b1;
    func_i <= fn;
    request_size_i <= size;
    block_address_i <= addr;
    do @(posedge clk_i); while (busy);
    r = allocator_reply(fn, size, addr);
    awaited_replies.push_back(typed ? want : r);
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_pool_base(logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_POOL_BASE;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    base_reg = value[ADDR_W-1:0];
  endtask

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && done_o) begin
      if (awaited_replies.size() == 0) begin
        bad_replies++;
        if (bad_replies <= REPORT_LIMIT)
          $display("%0t: result word with none pending: addr %h outcome %0d copy %0b",
                   $realtime, result_address_o, outcome_o, copy_needed_o);
      end else begin
        want = awaited_replies.pop_front();
        if (result_address_o !== want.addr || outcome_o !== want.outcome ||
            copy_needed_o !== want.copy) begin
          bad_replies++;
          if (bad_replies <= REPORT_LIMIT)
            $display("%0t: expected addr %h outcome %0d copy %0b, got addr %h outcome %0d copy %0b",
                     $realtime, want.addr, want.outcome, want.copy,
                     result_address_o, outcome_o, copy_needed_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("fixed_slot_allocator_top test failed");
      $finish;
    end
  end

  initial begin
    logic [FUNC_W-1:0] fn;
    logic [63:0] base_word;
    int roll;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_PLAN[i]) begin
      issue(DIRECTED_PLAN[i].fn, DIRECTED_PLAN[i].size, DIRECTED_PLAN[i].addr,
            DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
      hold_off(pick_gap(1'b1));
    end

    foreach (PHASES[p]) begin
      // base changes only with nothing in flight
      drain();
      base_word = {$urandom, $urandom};
      if (!PHASES[p].rand_base) base_word[ADDR_W-1:0] = PHASES[p].base;
      write_pool_base(base_word);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < PHASES[p].alloc_pct) fn = FUNC_ALLOC;
        else if (roll < 97) fn = $urandom_range(0, 1) ? FUNC_FREE : FUNC_REALLOC;
        else fn = FUNC_UNKNOWN;
        issue(fn, (fn == FUNC_UNKNOWN) ? $urandom : pick_size(fn),
              (fn == FUNC_ALLOC || fn == FUNC_UNKNOWN) ? ADDR_W'({$urandom, $urandom})
                                                        : pick_address(),
              1'b0, '0);
        hold_off(pick_gap(PHASES[p].idle_on));
      end
    end

    drain();
    if (bad_replies == 0 && awaited_replies.size() == 0) begin
      $display("fixed_slot_allocator_top test passed");
    end else begin
      $display("fixed_slot_allocator_top test failed");
    end
    $finish;
  end

endmodule
